// ----- hdl/jcs_pkg.sv -----
`default_nettype none

package jcs_pkg;

	// Depth of the result queue; it must hold at least the two results of one byte.
	localparam int FIFO_DEPTH = 4;

	// Characters with a meaning of their own in the text.
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// One result as it leaves the block.
	typedef struct packed {
		logic [7:0] char_out;
		logic       run_last;
		logic       text_end;
	} result_t;

	// Results produced by one byte: count of valid results, then the results in order.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

`default_nettype wire

// ----- hdl/jcs_scan.sv -----
`default_nettype none

module jcs_scan (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     char_in,
	input  wire logic           is_final,
	input  wire logic           room,
	output jcs_pkg::push_t      push
);
	import jcs_pkg::*;

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_STRING = 3'd1,
		M_ESCAPE = 3'd2,
		M_LINE   = 3'd3,
		M_BLOCK  = 3'd4,
		M_BSTAR  = 3'd5,
		M_SLASH  = 3'd6
	} mode_t;

	mode_t      mode_q;
	mode_t      mode_d;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       fin_s1;
	logic       advance;
	logic [1:0] n;
	logic [7:0] b0;

	// The input register moves on whenever the queue can take two more results.
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			fin_s1  <= is_final;
		end
	end

	// Scan mode transitions and the bytes that one input byte lets through.
	always_comb begin
		n      = 2'd0;
		b0     = char_s1;
		mode_d = mode_q;
		case (mode_q)
			M_STRING: begin
				n = 2'd1;
				if (char_s1 == CH_BSL) begin
					mode_d = M_ESCAPE;
				end else if (char_s1 == CH_QUOTE) begin
					mode_d = M_NORMAL;
				end
			end
			M_ESCAPE: begin
				n      = 2'd1;
				mode_d = M_STRING;
			end
			M_LINE: begin
				if (char_s1 == CH_NL) begin
					n      = 2'd1;
					mode_d = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (char_s1 == CH_STAR) begin
					mode_d = M_BSTAR;
				end
			end
			M_BSTAR: begin
				if (char_s1 == CH_SLASH) begin
					mode_d = M_NORMAL;
				end else if (char_s1 != CH_STAR) begin
					mode_d = M_BLOCK;
				end
			end
			M_SLASH: begin
				if (char_s1 == CH_SLASH) begin
					mode_d = M_LINE;
				end else if (char_s1 == CH_STAR) begin
					mode_d = M_BLOCK;
				end else begin
					// The held slash was no comment opener: release it before this byte.
					n      = 2'd2;
					b0     = CH_SLASH;
					mode_d = (char_s1 == CH_QUOTE) ? M_STRING : M_NORMAL;
				end
			end
			default: begin
				if (char_s1 == CH_QUOTE) begin
					n      = 2'd1;
					mode_d = M_STRING;
				end else if (char_s1 == CH_SLASH) begin
					mode_d = M_SLASH;
				end else begin
					n      = 2'd1;
					mode_d = M_NORMAL;
				end
			end
		endcase
		// At the end of the text a held slash goes out and the mode returns to normal.
		if (fin_s1) begin
			if (mode_d == M_SLASH) begin
				n  = 2'd1;
				b0 = CH_SLASH;
			end
			mode_d = M_NORMAL;
		end
	end

	// Mode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
		end else if (advance) begin
			mode_q <= mode_d;
		end
	end

	// Results handed to the queue.
	always_comb begin
		push.cnt           = advance ? n : 2'd0;
		push.res0.char_out = b0;
		push.res0.run_last = (n == 2'd1);
		push.res0.text_end = fin_s1;
		push.res1.char_out = char_s1;
		push.res1.run_last = 1'b1;
		push.res1.text_end = fin_s1;
	end

	// After the last byte of a text has been scanned, the mode is normal again.
	a_final_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin_s1) |=> (mode_q == M_NORMAL))
		else $error("mode not normal after final byte");

	// A pair of results always starts with a released slash.
	a_pair_starts_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.res0.char_out == CH_SLASH))
		else $error("result pair without leading slash");

	// Results appear only when the input register moves on.
	a_push_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> advance)
		else $error("results pushed without a scanned byte");

	// No slash stays held across the end of a text.
	a_no_held_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin_s1) |-> (mode_d == M_NORMAL))
		else $error("slash held past end of text");

endmodule

`default_nettype wire

// ----- hdl/jcs_out_fifo.sv -----
`default_nettype none

module jcs_out_fifo #(
	parameter int Depth = jcs_pkg::FIFO_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jcs_pkg::push_t  push,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           char_out,
	output logic                 run_last,
	output logic                 text_end
);
	import jcs_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	result_t         mem [Depth];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW-1:0]   wr1;
	logic [PW-1:0]   wr2;
	logic [CW-1:0]   count_q;
	logic            pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	// Room for the worst case of two results from the next byte.
	assign room      = (count_q <= CW'(Depth - 2));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign wr1       = ptr_inc(wr_q);
	assign wr2       = ptr_inc(wr1);

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr1] <= push.res1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push.cnt)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	// Head of the queue drives the result transfer.
	assign char_out = mem[rd_q].char_out;
	assign run_last = mem[rd_q].run_last;
	assign text_end = mem[rd_q].text_end;

	// The fill level never exceeds the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("result queue overflow");

	// Results are only pushed while there is room for them.
	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("push into a full result queue");

	// The fill level follows pushes and pops exactly.
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) + CW'($past(push.cnt)) - CW'($past(pop))))
		else $error("fill level out of step");

endmodule

`default_nettype wire

// ----- hdl/json_comment_stripper_top.sv -----
// JSON-with-comments stripper: takes one byte of text per transfer and passes on only the
// bytes that lie outside line and block comments, keeping the newline that closes a line
// comment and leaving quoted strings and their escapes untouched. A byte enters every cycle in which
// in_ready is high; it is scanned from the input register and its results then leave through the queue.
// A slash is held until the next byte shows whether it opens a comment, so a byte may give
// no result, one result, or two (the held slash, then the byte); run_last marks the last
// result of each byte and text_end marks every result of the byte flagged is_final. The
// results go into a small queue of FifoDepth entries, and in_ready stays high as long as
// that queue has two free entries, so the input rate is one byte per cycle for as long as
// the output side takes one result per cycle.
`default_nettype none

module json_comment_stripper_top #(
	parameter int FifoDepth = jcs_pkg::FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       is_final,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      char_out,
	output logic            run_last,
	output logic            text_end
);
	import jcs_pkg::*;

	push_t push;
	logic  room;

	// Mode tracking and result selection.
	jcs_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.is_final (is_final),
		.room     (room),
		.push     (push)
	);

	// Queue between the scanner and the result transfer.
	jcs_out_fifo #(
		.Depth (FifoDepth)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.run_last  (run_last),
		.text_end  (text_end)
	);

endmodule

`default_nettype wire
